/* rtl/irc_pkg.sv */
// ----------------------------------------------------------------------------
// irc_pkg: shared types and helpers for the IPv6 receive header check
// Holds the verdict codes, the next header numbers that matter, the header
// state record passed between the capture and verdict stages, and the
// ones-complement add.
// ----------------------------------------------------------------------------
package irc_pkg;

  // Fixed header length and count limits.
  localparam logic [15:0] HdrLen      = 16'd40;
  localparam logic [15:0] CountMax    = 16'hFFFF;
  localparam logic [3:0]  IpVersion   = 4'd6;

  // Byte offsets inside the fixed header.
  localparam logic [15:0] PosVersion  = 16'd0;
  localparam logic [15:0] PosLenHigh  = 16'd4;
  localparam logic [15:0] PosLenLow   = 16'd5;
  localparam logic [15:0] PosNextHdr  = 16'd6;
  localparam logic [15:0] PosAddrBase = 16'd8;

  // Next header numbers.
  localparam logic [7:0] NhHopByHop  = 8'd0;
  localparam logic [7:0] NhRouting   = 8'd43;
  localparam logic [7:0] NhFragment  = 8'd44;
  localparam logic [7:0] NhEsp       = 8'd50;
  localparam logic [7:0] NhAuth      = 8'd51;
  localparam logic [7:0] NhNoNext    = 8'd59;
  localparam logic [7:0] NhDestOpts  = 8'd60;

  typedef enum logic [2:0] {
    VerdictDeliver    = 3'd0,
    VerdictTooShort   = 3'd1,
    VerdictBadVersion = 3'd2,
    VerdictLenBad     = 3'd3,
    VerdictUnsupExt   = 3'd4,
    VerdictNoNext     = 3'd5
  } verdict_e;

  // Header state after the current byte has been taken in.
  typedef struct packed {
    logic [15:0] byte_count;
    logic [3:0]  version;
    logic [15:0] plen;
    logic [7:0]  next_header;
    logic [15:0] sum;
  } hdr_state_t;

  // Control for one processed word.
  typedef struct packed {
    logic fire;
    logic last;
  } step_t;

  // Ones-complement add with one end-around fold. Two 16-bit values sum to
  // at most 0x1FFFE, so a single fold always lands in 16 bits.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Classes the next header of a packet that passed the header checks.
  function automatic verdict_e classify(input logic [7:0] nh);
    verdict_e v;
    case (nh) inside
      NhHopByHop, NhRouting, NhFragment, NhEsp, NhAuth, NhDestOpts: begin
        v = VerdictUnsupExt;
      end
      NhNoNext: begin
        v = VerdictNoNext;
      end
      default: begin
        v = VerdictDeliver;
      end
    endcase
    return v;
  endfunction

endpackage

/* rtl/irc_capture.sv */
// ----------------------------------------------------------------------------
// irc_capture: per-packet header field capture
// Counts bytes, captures version, payload length and next header, and
// folds the source and destination addresses into a ones-complement sum.
// Shows the state as it stands after the current word; clears on the last.
// ----------------------------------------------------------------------------
module irc_capture (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  irc_pkg::step_t      step_i,
  input  logic [7:0]          data_byte_i,
  output irc_pkg::hdr_state_t state_o
);
  import irc_pkg::*;

  hdr_state_t state_q;
  hdr_state_t state_d;
  logic [7:0] hold_q;
  logic [7:0] hold_d;

  // Next header state from the current word and its position.
  always_comb begin
    logic [15:0] pos;
    logic        in_addr;
    pos     = state_q.byte_count;
    state_d = state_q;
    hold_d  = hold_q;
    in_addr = (pos >= PosAddrBase) && (pos < HdrLen);

    if (pos == PosVersion) begin
      state_d.version = data_byte_i[7:4];
    end else if (pos == PosLenHigh) begin
      state_d.plen = {data_byte_i, 8'd0};
    end else if (pos == PosLenLow) begin
      state_d.plen = {state_q.plen[15:8], data_byte_i};
    end else if (pos == PosNextHdr) begin
      state_d.next_header = data_byte_i;
    end else if (in_addr) begin
      if (!pos[0]) begin
        hold_d = data_byte_i;
      end else begin
        state_d.sum = ones_add(state_q.sum, {hold_q, data_byte_i});
      end
    end

    // The count sticks at its maximum on very long packets.
    if (pos != CountMax) begin
      state_d.byte_count = pos + 16'd1;
    end
  end

  assign state_o = state_d;

  // State registers; a packet's last word leaves them clear for the next.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      hold_q  <= '0;
    end else if (step_i.fire) begin
      if (step_i.last) begin
        state_q <= '0;
        hold_q  <= '0;
      end else begin
        state_q <= state_d;
        hold_q  <= hold_d;
      end
    end
  end

endmodule

/* rtl/irc_verdict.sv */
// ----------------------------------------------------------------------------
// irc_verdict: end-of-packet decision and result register
// Checks length, version and payload length against the byte count, forms
// the pseudo-header checksum and the tail trim, and holds the result word
// until the downstream side takes it.
// ----------------------------------------------------------------------------
module irc_verdict (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  irc_pkg::step_t      step_i,
  input  irc_pkg::hdr_state_t state_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [2:0]          verdict_o,
  output logic [7:0]          next_header_o,
  output logic [15:0]         payload_length_o,
  output logic [15:0]         pseudo_checksum_o,
  output logic [15:0]         trim_bytes_o
);
  import irc_pkg::*;

  logic        valid_q;
  verdict_e    verdict_d, verdict_q;
  logic [15:0] csum_d, csum_q;
  logic [15:0] trim_d, trim_q;
  logic [7:0]  nh_q;
  logic [15:0] plen_q;
  logic        load;

  // Verdict, checksum and trim for the packet that ends with this word.
  always_comb begin
    logic [16:0] need;
    logic [15:0] len;
    logic [15:0] s1;
    logic [15:0] s2;
    need      = {1'b0, state_i.plen} + {1'b0, HdrLen};
    len       = state_i.byte_count - HdrLen;
    s1        = ones_add(state_i.sum, len);
    s2        = ones_add(s1, {8'd0, state_i.next_header});
    csum_d    = '0;
    trim_d    = '0;
    if (state_i.byte_count < HdrLen) begin
      verdict_d = VerdictTooShort;
    end else if (state_i.version != IpVersion) begin
      verdict_d = VerdictBadVersion;
    end else if (need > {1'b0, state_i.byte_count}) begin
      verdict_d = VerdictLenBad;
    end else begin
      verdict_d = classify(state_i.next_header);
      csum_d    = (s2 == 16'd0) ? 16'd0 : ~s2;
      trim_d    = len - state_i.plen;
    end
  end

  assign load = step_i.fire && step_i.last;

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Result payload; loaded only when the slot is free or being emptied.
  always_ff @(posedge clk_i) begin
    if (load) begin
      verdict_q <= verdict_d;
      nh_q      <= state_i.next_header;
      plen_q    <= state_i.plen;
      csum_q    <= csum_d;
      trim_q    <= trim_d;
    end
  end

  assign out_valid_o       = valid_q;
  assign verdict_o         = verdict_q;
  assign next_header_o     = nh_q;
  assign payload_length_o  = plen_q;
  assign pseudo_checksum_o = csum_q;
  assign trim_bytes_o      = trim_q;

endmodule

/* rtl/ipv6_header_receive_check.sv */
// ----------------------------------------------------------------------------
// ipv6_header_receive_check: IPv6 receive header check
// Takes a packet one byte per word, checks the fixed header and gives one
// verdict word per packet with the pseudo-header checksum and tail trim.
//
//   Channel | Dir | Handshake              | Fields
//   in      | in  | in_valid_i, in_stall_o | data_byte_i, last_byte_i
//   out     | out | out_valid_o, out_stall_i | verdict_o, next_header_o,
//           |     |                        | payload_length_o,
//           |     |                        | pseudo_checksum_o, trim_bytes_o
//
// One byte word is taken every cycle unless the input stalls. A word sits
// in the input register before it is folded into the header state, and the
// verdict word is registered when the last byte leaves the input register.
// The input stalls only while a last byte waits for a result still held
// by a stalled output. Reset clears all control and header state; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module ipv6_header_receive_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  verdict_o,
  output logic [7:0]  next_header_o,
  output logic [15:0] payload_length_o,
  output logic [15:0] pseudo_checksum_o,
  output logic [15:0] trim_bytes_o
);
  import irc_pkg::*;

  logic       in_valid_q;
  logic [7:0] data_q;
  logic       last_q;
  logic       out_free;
  logic       take;
  step_t      step;
  hdr_state_t hdr_state;

  // A last byte needs a free result slot; other bytes always move on.
  assign out_free   = !out_valid_o || !out_stall_i;
  assign step.fire  = in_valid_q && (!last_q || out_free);
  assign step.last  = last_q;
  assign in_stall_o = in_valid_q && !step.fire;
  assign take       = in_valid_i && !in_stall_o;

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= 1'b1;
    end else if (step.fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  irc_capture u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (data_q),
    .state_o     (hdr_state)
  );

  irc_verdict u_verdict (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .state_i           (hdr_state),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .verdict_o         (verdict_o),
    .next_header_o     (next_header_o),
    .payload_length_o  (payload_length_o),
    .pseudo_checksum_o (pseudo_checksum_o),
    .trim_bytes_o      (trim_bytes_o)
  );

  // A processed last byte always leaves a result word behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.fire && step.last |=> out_valid_o)
    else $error("last byte processed without a result word");

  // The input only stalls behind a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && last_q && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // Dropped packets carry no checksum and no trim.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VerdictTooShort || verdict_o == VerdictBadVersion ||
                    verdict_o == VerdictLenBad)
    |-> pseudo_checksum_o == 16'd0 && trim_bytes_o == 16'd0)
    else $error("dropped packet with nonzero checksum or trim");

endmodule

/* tb/ipv6_header_receive_check_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv6_header_receive_check_tb: self-checking bench for the IPv6 receive check
// Streams IPv6 packets byte by byte into the block and predicts each verdict
// word from its own model of the header capture, the address sum and the
// verdict rules. The directed packets cover cut-off headers, bad versions,
// the length boundary, every next header class, the special checksum sums
// and a packet with a tail. The random packets are mostly well formed,
// with some broken ones. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module ipv6_header_receive_check_tb;
  import irc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_word_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  next_header;
    logic [15:0] payload_length;
    logic [15:0] pseudo_checksum;
    logic [15:0] trim_bytes;
  } verdict_word_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i  = 8'd0;
  logic        last_byte_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [2:0]  verdict_o;
  logic [7:0]  next_header_o;
  logic [15:0] payload_length_o;
  logic [15:0] pseudo_checksum_o;
  logic [15:0] trim_bytes_o;

  // Words waiting to be sent and verdicts waiting to arrive.
  rx_word_t      byte_feed[$];
  verdict_word_t verdicts_due[$];
  logic [7:0]    pkt_bytes[$];

  logic in_accepted   = 1'b0;
  int   err_count     = 0;
  int   verdicts_seen = 0;
  bit   steady;

  // Header state of the packet now streaming in.
  logic [15:0] pos_count = 16'd0;
  logic [3:0]  ver_nib   = 4'd0;
  logic [15:0] plen_cap  = 16'd0;
  logic [7:0]  nh_cap    = 8'd0;
  logic [15:0] addr_sum  = 16'd0;
  logic [7:0]  hi_hold   = 8'd0;

  ipv6_header_receive_check dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .verdict_o        (verdict_o),
    .next_header_o    (next_header_o),
    .payload_length_o (payload_length_o),
    .pseudo_checksum_o(pseudo_checksum_o),
    .trim_bytes_o     (trim_bytes_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // A stretch of packets runs with neither side idling.
  assign steady = (verdicts_seen >= 5) && (verdicts_seen < 13);

  function automatic bit hold_off();
    return !steady && ($urandom_range(99) < 6);
  endfunction

  // Ones-complement add of two 16-bit words with the end-around carry.
  function automatic logic [15:0] add_1c(input logic [15:0] x, input logic [15:0] y);
    logic [16:0] t;
    t = {1'b0, x} + {1'b0, y};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function automatic verdict_e nh_class(input logic [7:0] nh);
    if (nh == NhNoNext) return VerdictNoNext;
    if (nh == NhHopByHop || nh == NhRouting || nh == NhFragment ||
        nh == NhEsp || nh == NhAuth || nh == NhDestOpts) return VerdictUnsupExt;
    return VerdictDeliver;
  endfunction

  // Folds one accepted byte into the header state; on the last byte the
  // verdict word is worked out and the state starts over.
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    logic [15:0]   span;
    logic [15:0]   s;
    verdict_word_t rec;
    if (pos_count == PosVersion) begin
      ver_nib = b[7:4];
    end else if (pos_count == PosLenHigh) begin
      plen_cap = {b, 8'h00};
    end else if (pos_count == PosLenLow) begin
      plen_cap = {plen_cap[15:8], b};
    end else if (pos_count == PosNextHdr) begin
      nh_cap = b;
    end else if (pos_count >= PosAddrBase && pos_count < HdrLen) begin
      if (!pos_count[0]) hi_hold = b;
      else addr_sum = add_1c(addr_sum, {hi_hold, b});
    end
    if (pos_count != CountMax) pos_count = pos_count + 16'd1;
    if (last) begin
      rec.next_header     = nh_cap;
      rec.payload_length  = plen_cap;
      rec.pseudo_checksum = 16'd0;
      rec.trim_bytes      = 16'd0;
      if (pos_count < HdrLen) begin
        rec.verdict = VerdictTooShort;
      end else if (ver_nib != IpVersion) begin
        rec.verdict = VerdictBadVersion;
      end else if ({1'b0, plen_cap} + {1'b0, HdrLen} > {1'b0, pos_count}) begin
        rec.verdict = VerdictLenBad;
      end else begin
        span = pos_count - HdrLen;
        s = add_1c(add_1c(addr_sum, span), {8'h00, nh_cap});
        rec.pseudo_checksum = (s == 16'd0) ? 16'd0 : ~s;
        rec.trim_bytes      = span - plen_cap;
        rec.verdict         = nh_class(nh_cap);
      end
      verdicts_due.push_back(rec);
      pos_count = 16'd0;
      ver_nib   = 4'd0;
      plen_cap  = 16'd0;
      nh_cap    = 8'd0;
      addr_sum  = 16'd0;
      hi_hold   = 8'd0;
    end
  endtask

  task automatic check_verdict();
    verdict_word_t rec;
    if (verdicts_due.size() == 0) begin
      $error("verdict word with no packet outstanding: verdict %0d", verdict_o);
      err_count++;
    end else begin
      rec = verdicts_due.pop_front();
      if (verdict_o !== rec.verdict) begin
        $error("verdict: expected %0d, got %0d", rec.verdict, verdict_o);
        err_count++;
      end
      if (next_header_o !== rec.next_header) begin
        $error("next_header: expected %0d, got %0d", rec.next_header, next_header_o);
        err_count++;
      end
      if (payload_length_o !== rec.payload_length) begin
        $error("payload_length: expected %0d, got %0d", rec.payload_length,
               payload_length_o);
        err_count++;
      end
      if (pseudo_checksum_o !== rec.pseudo_checksum) begin
        $error("pseudo_checksum: expected %h, got %h", rec.pseudo_checksum,
               pseudo_checksum_o);
        err_count++;
      end
      if (trim_bytes_o !== rec.trim_bytes) begin
        $error("trim_bytes: expected %0d, got %0d", rec.trim_bytes, trim_bytes_o);
        err_count++;
      end
    end
    verdicts_seen++;
  endtask

  // Monitor: checks each verdict word taken and predicts from each byte taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_verdict();
      if (in_valid_i && !in_stall_o) absorb_byte(data_byte_i, last_byte_i);
      in_accepted <= in_valid_i && !in_stall_o;
    end
  end

  // Driver: a word stays on the bus until it is taken.
  always @(negedge clk_i) begin
    rx_word_t nxt;
    if (rst_ni) begin
      if (!in_valid_i || in_accepted) begin
        if (byte_feed.size() > 0 && !hold_off()) begin
          nxt = byte_feed.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= nxt.data;
          last_byte_i <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= hold_off();
    end
  end

  // Packet builder: random bytes with the header fields laid over them.
  task automatic make_packet(input logic [3:0] ver, input logic [15:0] plen,
                             input logic [7:0] nh, input int total);
    pkt_bytes.delete();
    for (int i = 0; i < total; i++) pkt_bytes.push_back(8'($urandom));
    if (total > 0) pkt_bytes[0] = {ver, pkt_bytes[0][3:0]};
    if (total > 4) pkt_bytes[4] = plen[15:8];
    if (total > 5) pkt_bytes[5] = plen[7:0];
    if (total > 6) pkt_bytes[6] = nh;
  endtask

  task automatic fill_addr(input logic [7:0] v);
    for (int i = 8; i < 40 && i < pkt_bytes.size(); i++) pkt_bytes[i] = v;
  endtask

  task automatic send_packet();
    rx_word_t w;
    foreach (pkt_bytes[i]) begin
      w.data = pkt_bytes[i];
      w.last = (i == pkt_bytes.size() - 1);
      byte_feed.push_back(w);
    end
  endtask

  function automatic logic [7:0] pick_nh(input int k);
    case (k)
      0:       return NhHopByHop;
      1:       return NhRouting;
      2:       return NhFragment;
      3:       return NhEsp;
      4:       return NhAuth;
      5:       return NhDestOpts;
      6:       return NhNoNext;
      7:       return 8'd6;
      8:       return 8'd17;
      default: return 8'($urandom);
    endcase
  endfunction

  // Stimulus and end of run.
  initial begin
    int          total;
    int          sent_bytes;
    int          sent_pkts;
    int          r;
    logic [15:0] plen;
    logic [7:0]  nh;
    logic [3:0]  ver;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Headers cut off before and after each captured field.
    make_packet(IpVersion, 16'h1234, 8'd17, 1);   send_packet();
    make_packet(IpVersion, 16'hA5C3, 8'd17, 5);   send_packet();
    make_packet(IpVersion, 16'h0010, 8'd99, 7);   send_packet();
    make_packet(IpVersion, 16'h0000, 8'd6, 39);   send_packet();
    // Wrong versions.
    make_packet(4'h0, 16'd0, 8'd6, 40);           send_packet();
    make_packet(4'hF, 16'd0, 8'd17, 40);          send_packet();
    // Payload length one past the data, exactly at it, and at its maximum.
    make_packet(IpVersion, 16'd2, 8'd17, 41);     send_packet();
    make_packet(IpVersion, 16'd1, 8'd17, 41);     send_packet();
    make_packet(IpVersion, 16'hFFFF, 8'd17, 40);  send_packet();
    // Each extension header class and the no next header case; the
    // hop-by-hop class comes with the zero sum packet below.
    for (int i = 1; i < 7; i++) begin
      make_packet(IpVersion, 16'd0, pick_nh(i), 40);
      send_packet();
    end
    // Delivery with every address bit set.
    make_packet(IpVersion, 16'd8, 8'hFF, 48);
    fill_addr(8'hFF);
    send_packet();
    // The sum comes out zero.
    make_packet(IpVersion, 16'd0, NhHopByHop, 40);
    fill_addr(8'h00);
    send_packet();
    // The sum comes out all ones, so the checksum is zero as well.
    make_packet(IpVersion, 16'd0, 8'd17, 40);
    fill_addr(8'h00);
    pkt_bytes[8] = 8'hFF;
    pkt_bytes[9] = 8'hEE;
    send_packet();
    // A packet with a tail past the payload.
    make_packet(IpVersion, 16'd0, 8'd17, 64);     send_packet();

    // Random packets: mostly well formed, some broken, some cut short.
    sent_bytes = 0;
    sent_pkts  = 0;
    while (sent_bytes < 200 || sent_pkts < 3) begin
      r = $urandom_range(99);
      if (r < 80) begin
        total = 40 + (($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(24));
        if ($urandom_range(99) < 85) plen = 16'($urandom_range(total - 40));
        else if ($urandom_range(1) == 1) plen = 16'(total - 39);
        else plen = 16'($urandom);
        nh = ($urandom_range(1) == 1) ? pick_nh($urandom_range(8)) : 8'($urandom);
        make_packet(IpVersion, plen, nh, total);
      end else if (r < 90) begin
        total = 40 + $urandom_range(24);
        ver   = 4'($urandom);
        make_packet(ver, 16'($urandom_range(total - 40)), pick_nh($urandom_range(9)),
                    total);
      end else begin
        total = 1 + $urandom_range(38);
        make_packet(4'($urandom), 16'($urandom), 8'($urandom), total);
      end
      send_packet();
      sent_bytes += total;
      sent_pkts++;
    end

    // Drain: all bytes taken, all verdicts in, then a short settle.
    while (byte_feed.size() != 0 || in_valid_i) @(posedge clk_i);
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
